[design/wbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted bin tally package
// Shared types and constants for the weighted bin tally with event moments.
// ----------------------------------------------------------------------------
package wbt_pkg;

   localparam int unsigned NUM_COEF = 7;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   localparam logic TRUE  = 1'b1;
   localparam logic FALSE = 1'b0;

   typedef enum logic [1:0] {
      OP_FILL = 2'd0,
      OP_EVENT = 2'd1,
      OP_READ = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_DOSE_MASK = 1'd0,
      REG_BINS_USED = 1'd1
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  bin;
      logic [31:0] weight;
      logic [NUM_COEF-1:0][31:0] coef;
      logic [2:0]  dose_select;
   } req_item_type;

   typedef struct packed {
      logic [47:0] bin_flux;
      logic [62:0] bin_sum_sq;
      logic [62:0] bin_sum_cube;
      logic [62:0] bin_sum_fourth;
      logic [31:0] bin_hits;
      logic [62:0] dose_total;
      logic [47:0] event_sum;
   } rsp_item_type;

   // Saturating add of two 63-bit values.
   function automatic logic [62:0] add_sat63(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? MAX63 : s[62:0];
   endfunction

   function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

endpackage : wbt_pkg
`default_nettype wire

[design/wbt_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one tally request beat.
// ----------------------------------------------------------------------------
interface wbt_req_if import wbt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : wbt_req_if
`default_nettype wire

[design/wbt_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one tally result beat.
// ----------------------------------------------------------------------------
interface wbt_rsp_if import wbt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : wbt_rsp_if
`default_nettype wire

[design/weighted_bin_tally_moments.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted bin tally with event moments
// Top level: request queue, tally engine, register port.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bin memories to zero, and the engine
// takes no request beat until that ends. Requests enter a two-entry queue
// and are run one at a time by the engine. A fill reads and updates its bin
// and then adds the dose products, a read only reads its bin, and an end of
// event walks the bins in use one by one, paced by the single shared multiplier
// that forms the three powers of each bin's change; the result is then
// moved into the output register.
module weighted_bin_tally_moments
   import wbt_pkg::*;
#(
   parameter int unsigned MAX_BINS  = 64,
   parameter int unsigned NUM_DOSES = 7
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wbt_req_if.sink    req,
   wbt_rsp_if.source  rsp,
   input  wire logic  csr_psel,
   input  wire logic  csr_penable,
   input  wire logic  csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [6:0]   dose_mask_ff;
   logic [6:0]   bins_used_ff;
   logic         q_valid, q_ready, eng_busy;
   req_item_type q_data;
   logic         csr_wr;
   logic         reg_sel;

   assign csr_pready = TRUE;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dose_mask_ff <= 7'd1;
         bins_used_ff <= 7'd64;
      end else if (csr_wr && csr_paddr[1:0] == 2'd0) begin
         if (reg_index_type'(reg_sel) == REG_DOSE_MASK) dose_mask_ff <= csr_pwdata[6:0];
         else bins_used_ff <= csr_pwdata[6:0];
      end
   end

   // Register reads.
   always_comb begin
      case (reg_index_type'(reg_sel))
         REG_DOSE_MASK: csr_prdata = {25'd0, dose_mask_ff};
         REG_BINS_USED: csr_prdata = {25'd0, bins_used_ff};
         default:       csr_prdata = '0;
      endcase
   end

   wbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req.data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   wbt_engine #(
      .MAX_BINS  (MAX_BINS),
      .NUM_DOSES (NUM_DOSES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .dose_mask (dose_mask_ff),
      .bins_used (bins_used_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data),
      .busy      (eng_busy)
   );

   // The engine only takes a beat while it is idle.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !eng_busy)
      else $error("engine took a beat while busy");

   // A result appears only after the engine has been busy.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(eng_busy))
      else $error("result without work");

   // A pending result never changes while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(rsp.data))
      else $error("stalled result changed");

endmodule : weighted_bin_tally_moments
`default_nettype wire

[design/wbt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue
// Two-entry FIFO that decouples request intake from the tally engine.
// ----------------------------------------------------------------------------
module wbt_queue
   import wbt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_item_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output req_item_type      out_data
);

   req_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   // Handshake on both sides.
   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule : wbt_queue
`default_nettype wire

[design/wbt_power_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Moment power unit
// Forms the 2nd, 3rd and 4th powers of a Q16.16 change, one multiply a step.
// ----------------------------------------------------------------------------
module wbt_power_unit
   import wbt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] change,
   output logic             done,
   output logic [62:0]      pow2,
   output logic [62:0]      pow3,
   output logic [62:0]      pow4
);

   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] change_ff;
   logic [62:0] acc_ff, acc_in;
   logic [62:0] p2_ff, p3_ff;
   logic [62:0] mul_a;
   logic [63:0] prod_hi;
   logic [63:0] prod_lo;
   logic [63:0] res;

   // Operand is the change for the square, the last power after that.
   assign mul_a = (step_ff == 2'd0) ? {31'd0, change_ff} : acc_ff;

   // Split 63 by 32 multiply: high half 31 bits, low half 32 bits.
   always_comb begin
      prod_hi = {33'd0, mul_a[62:32]} * {32'd0, change_ff};
      prod_lo = {32'd0, mul_a[31:0]} * {32'd0, change_ff};
      if (prod_hi >= 64'h0000_8000_0000_0000) begin
         res = {1'b0, MAX63};
      end else begin
         res = (prod_hi << 16) + {16'd0, prod_lo[63:16]};
         if (res[63]) res = {1'b0, MAX63};
      end
      acc_in = res[62:0];
   end

   // Step control.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = TRUE;
         step_in = 2'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) busy_in = FALSE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= FALSE;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) change_ff <= change;
      if (busy_ff) begin
         acc_ff <= acc_in;
         if (step_ff == 2'd0) p2_ff <= acc_in;
         if (step_ff == 2'd1) p3_ff <= acc_in;
      end
   end

   // The fourth power sits in the accumulator from the cycle after done.
   assign done = busy_ff && (step_ff == 2'd2);
   assign pow2 = p2_ff;
   assign pow3 = p3_ff;
   assign pow4 = acc_ff;

endmodule : wbt_power_unit
`default_nettype wire

[design/wbt_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tally engine
// Back end: clear sweep, fills, end-of-event walk and read-out over the bin memories.
// ----------------------------------------------------------------------------
module wbt_engine
   import wbt_pkg::*;
#(
   parameter int unsigned MAX_BINS  = 64,
   parameter int unsigned NUM_DOSES = 7
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [6:0]   dose_mask,
   input  wire logic [6:0]   bins_used,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_item_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_data,
   output logic              busy
);

   localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int unsigned CW = $clog2(MAX_BINS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_RD, S_FILL, S_DOSE, S_WALK_RD, S_WALK_POW,
      S_WALK_WAIT, S_WALK_WR, S_OUT_RD, S_OUT
   } state_type;

   // Bin memories.
   logic [47:0] flux_mem  [MAX_BINS];
   logic [47:0] prev_mem  [MAX_BINS];
   logic [62:0] m2_mem    [MAX_BINS];
   logic [62:0] m3_mem    [MAX_BINS];
   logic [62:0] m4_mem    [MAX_BINS];
   logic [31:0] hit_mem   [MAX_BINS];
   logic [62:0] dose_ff   [NUM_DOSES];

   state_type    state_ff, state_in;
   req_item_type item_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] limit;
   logic [2:0]   dose_ff_idx, dose_idx_in;
   logic [AW-1:0] addr;
   logic         mem_we, walk_we, clr_we;
   logic         bin_ok;
   logic [47:0]  flux_rd, prev_rd;
   logic [62:0]  m2_rd, m3_rd, m4_rd;
   logic [31:0]  hit_rd;
   logic [47:0]  esum_ff;
   logic [31:0]  change;
   logic [47:0]  diff;
   logic [31:0]  chg_ff;
   logic         pow_start, pow_done;
   logic [62:0]  p2, p3, p4;
   logic [63:0]  dose_prod_ff;
   logic [62:0]  dose_sel;
   logic         out_valid_ff;
   rsp_item_type out_ff;
   logic [32:0]  hit_sum;
   logic [2:0]   last_dose;

   assign last_dose = 3'(NUM_DOSES - 1);
   assign limit  = (32'(bins_used) > 32'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(bins_used);
   assign bin_ok = ({26'd0, item_ff.bin} < 32'(MAX_BINS));

   // Memory address: walk or clear index, else the item's bin.
   always_comb begin
      if (state_ff == S_CLEAR || state_ff == S_WALK_RD || state_ff == S_WALK_POW
          || state_ff == S_WALK_WAIT || state_ff == S_WALK_WR) begin
         addr = idx_ff[AW-1:0];
      end else begin
         addr = AW'(item_ff.bin);
      end
   end

   assign clr_we  = (state_ff == S_CLEAR);
   assign mem_we  = (state_ff == S_FILL) && bin_ok;
   assign walk_we = (state_ff == S_WALK_WR);

   // Registered memory reads.
   always_ff @(posedge clock) begin
      flux_rd <= flux_mem[addr];
      prev_rd <= prev_mem[addr];
      m2_rd   <= m2_mem[addr];
      m3_rd   <= m3_mem[addr];
      m4_rd   <= m4_mem[addr];
      hit_rd  <= hit_mem[addr];
   end

   assign hit_sum = {1'b0, hit_rd} + 33'd1;

   // Memory writes.
   always_ff @(posedge clock) begin
      if (clr_we) begin
         flux_mem[addr] <= '0;
         prev_mem[addr] <= '0;
         m2_mem[addr]   <= '0;
         m3_mem[addr]   <= '0;
         m4_mem[addr]   <= '0;
         hit_mem[addr]  <= '0;
      end else if (mem_we) begin
         flux_mem[addr] <= add_sat48(flux_rd, {16'd0, item_ff.weight});
         hit_mem[addr]  <= hit_sum[32] ? MAX32 : hit_sum[31:0];
      end else if (walk_we) begin
         m2_mem[addr]   <= add_sat63(m2_rd, p2);
         m3_mem[addr]   <= add_sat63(m3_rd, p3);
         m4_mem[addr]   <= add_sat63(m4_rd, p4);
         prev_mem[addr] <= flux_rd;
      end
   end

   // Change since the previous event, saturated to Q16.16.
   assign diff   = (flux_rd >= prev_rd) ? (flux_rd - prev_rd) : 48'd0;
   assign change = (diff[47:32] != 16'd0) ? MAX32 : diff[31:0];
   assign pow_start = (state_ff == S_WALK_POW);

   wbt_power_unit u_pow (
      .clock  (clock),
      .reset  (reset),
      .start  (pow_start),
      .change (change),
      .done   (pow_done),
      .pow2   (p2),
      .pow3   (p3),
      .pow4   (p4)
   );

   // Next state.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      dose_idx_in = dose_ff_idx;
      case (state_ff)
         S_CLEAR: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(MAX_BINS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid) begin
               idx_in      = '0;
               dose_idx_in = '0;
               case (op_type'(in_data.op))
                  OP_FILL:  state_in = S_RD;
                  OP_EVENT: state_in = S_WALK_RD;
                  default:  state_in = S_OUT_RD;
               endcase
            end
         end
         S_RD: state_in = S_FILL;
         S_FILL: state_in = bin_ok ? S_DOSE : S_OUT_RD;
         S_DOSE: begin
            dose_idx_in = dose_ff_idx + 3'd1;
            if (dose_ff_idx == last_dose) state_in = S_OUT_RD;
         end
         S_WALK_RD: state_in = (idx_ff >= limit) ? S_OUT_RD : S_WALK_POW;
         S_WALK_POW: state_in = S_WALK_WAIT;
         S_WALK_WAIT: if (pow_done) state_in = S_WALK_WR;
         S_WALK_WR: begin
            idx_in   = idx_ff + CW'(1);
            state_in = S_WALK_RD;
         end
         S_OUT_RD: state_in = S_OUT;
         S_OUT: if (!out_valid_ff || out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         idx_ff      <= '0;
         dose_ff_idx <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         dose_ff_idx <= dose_idx_in;
      end
   end

   // Capture the request and the change of the current walk bin.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && in_valid) item_ff <= in_data;
      if (state_ff == S_WALK_POW) chg_ff <= change;
   end

   // Dose product for the next dose, registered ahead of its add.
   always_ff @(posedge clock) begin
      if (state_ff == S_FILL) begin
         dose_prod_ff <= {32'd0, item_ff.weight} * {32'd0, item_ff.coef[0]};
      end else if (state_ff == S_DOSE && dose_ff_idx != last_dose) begin
         dose_prod_ff <= {32'd0, item_ff.weight} * {32'd0, item_ff.coef[dose_ff_idx + 3'd1]};
      end
   end

   // Dose totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(NUM_DOSES); i++) dose_ff[i] <= '0;
      end else if (state_ff == S_DOSE && dose_mask[dose_ff_idx]) begin
         dose_ff[dose_ff_idx] <= add_sat63(dose_ff[dose_ff_idx], {15'd0, dose_prod_ff[63:16]});
      end
   end

   // Event sum.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) esum_ff <= '0;
      else if (state_ff == S_WALK_WR) esum_ff <= add_sat48(esum_ff, {16'd0, chg_ff});
   end

   assign dose_sel = ({29'd0, item_ff.dose_select} < 32'(NUM_DOSES))
                     ? dose_ff[item_ff.dose_select] : '0;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= FALSE;
      end else begin
         if (state_ff == S_OUT && (!out_valid_ff || out_ready)) out_valid_ff <= TRUE;
         else if (out_ready) out_valid_ff <= FALSE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!out_valid_ff || out_ready)) begin
         out_ff.bin_flux       <= bin_ok ? flux_rd : '0;
         out_ff.bin_sum_sq     <= bin_ok ? m2_rd : '0;
         out_ff.bin_sum_cube   <= bin_ok ? m3_rd : '0;
         out_ff.bin_sum_fourth <= bin_ok ? m4_rd : '0;
         out_ff.bin_hits       <= bin_ok ? hit_rd : '0;
         out_ff.dose_total     <= dose_sel;
         out_ff.event_sum      <= (op_type'(item_ff.op) == OP_EVENT) ? esum_ff : '0;
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign busy      = (state_ff != S_IDLE);

endmodule : wbt_engine
`default_nettype wire

[tb/sv/tb_weighted_bin_tally_moments.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted bin tally testbench
// Drives fill, end-of-event and read beats with random gaps and back-pressure,
// writes the dose mask and bin count between phases, and checks every result
// beat field by field against a tally predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_weighted_bin_tally_moments;
   import wbt_pkg::*;

   localparam int NBINS = 64;
   localparam int NDOSE = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   wbt_req_if req ();
   wbt_rsp_if rsp ();

   weighted_bin_tally_moments dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Tally shadow state.
   logic [47:0] flux_m [NBINS];
   logic [47:0] prev_m [NBINS];
   logic [62:0] mom2_m [NBINS];
   logic [62:0] mom3_m [NBINS];
   logic [62:0] mom4_m [NBINS];
   logic [31:0] hits_m [NBINS];
   logic [62:0] dose_m [NDOSE];
   logic [6:0] mask_m;
   logic [6:0] used_m;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int errors = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

   function automatic logic [62:0] sat_add63(logic [62:0] a, logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? MAX63 : s[62:0];
   endfunction

   // Exact (a*b)>>16, saturated to 63 bits.
   function automatic logic [62:0] q16_mul(logic [62:0] a, logic [31:0] b);
      logic [94:0] p;
      p = ({32'b0, a} * {63'b0, b}) >> 16;
      return (p > {32'b0, MAX63}) ? MAX63 : p[62:0];
   endfunction

   // Apply one request to the shadow state and return its result beat.
   function automatic rsp_item_type tally_step(req_item_type it);
      rsp_item_type r;
      logic [47:0] esum;
      logic [47:0] ch;
      logic [62:0] p2, p3, p4;
      logic [63:0] term;
      int n;
      esum = '0;
      if (it.op == OP_FILL) begin
         flux_m[it.bin] = sat_add48(flux_m[it.bin], {16'b0, it.weight});
         hits_m[it.bin] = (hits_m[it.bin] == MAX32) ? MAX32 : hits_m[it.bin] + 32'd1;
         for (int d = 0; d < NDOSE; d++) begin
            if (mask_m[d]) begin
               term = ({32'b0, it.weight} * {32'b0, it.coef[d]}) >> 16;
               dose_m[d] = sat_add63(dose_m[d], term[62:0]);
            end
         end
      end else if (it.op == OP_EVENT) begin
         n = (used_m > NBINS) ? NBINS : used_m;
         for (int i = 0; i < n; i++) begin
            ch = flux_m[i] - prev_m[i];
            if (ch > {16'b0, MAX32}) ch = {16'b0, MAX32};
            p2 = q16_mul({15'b0, ch}, ch[31:0]);
            p3 = q16_mul(p2, ch[31:0]);
            p4 = q16_mul(p3, ch[31:0]);
            mom2_m[i] = sat_add63(mom2_m[i], p2);
            mom3_m[i] = sat_add63(mom3_m[i], p3);
            mom4_m[i] = sat_add63(mom4_m[i], p4);
            prev_m[i] = flux_m[i];
            esum = sat_add48(esum, ch);
         end
      end
      r.bin_flux = flux_m[it.bin];
      r.bin_sum_sq = mom2_m[it.bin];
      r.bin_sum_cube = mom3_m[it.bin];
      r.bin_sum_fourth = mom4_m[it.bin];
      r.bin_hits = hits_m[it.bin];
      r.dose_total = (it.dose_select < NDOSE) ? dose_m[it.dose_select] : '0;
      r.event_sum = esum;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      errors++;
   endtask

   // Register write over the APB-style port; shadow copy updated alongside.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * idx);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_DOSE_MASK) mask_m = value[6:0];
      else used_m = value[6:0];
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h3_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type rand_req(int fill_pct);
      req_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < fill_pct) it.op = OP_FILL;
      else if (pick < fill_pct + 12) it.op = OP_EVENT;
      else if (pick < 97) it.op = OP_READ;
      else it.op = OP_SPARE;
      // Keep most activity in the low bins so short event walks see it.
      it.bin = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      it.weight = rand_word();
      for (int d = 0; d < NDOSE; d++) it.coef[d] = rand_word();
      it.dose_select = 3'($urandom);
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      // Allow the engine to settle before touching registers.
      repeat (40) @(posedge clock);
   endtask

   // Handshakes seen at the rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req.valid && req.ready;
   end

   // Request driver: a random gap after each accepted beat.
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= '0;
      end else if (req.valid && !req_taken) begin
         // Hold the beat until accepted.
      end else begin
         if (req_taken) begin
            expected_rsps.push_back(tally_step(req.data));
            void'(pending_reqs.pop_front());
            gap_left = $urandom_range(0, 3);
         end
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req.valid <= 1'b0;
         end else begin
            req.valid <= 1'b1;
            req.data <= pending_reqs[0];
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      rsp_item_type want, got;
      rsp_taken <= !reset && rsp.valid && rsp.ready;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.data;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected beat", '0, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.bin_flux !== want.bin_flux)
               report_mismatch("bin_flux", got.bin_flux, want.bin_flux);
            if (got.bin_sum_sq !== want.bin_sum_sq)
               report_mismatch("bin_sum_sq", got.bin_sum_sq, want.bin_sum_sq);
            if (got.bin_sum_cube !== want.bin_sum_cube)
               report_mismatch("bin_sum_cube", got.bin_sum_cube, want.bin_sum_cube);
            if (got.bin_sum_fourth !== want.bin_sum_fourth)
               report_mismatch("bin_sum_fourth", got.bin_sum_fourth, want.bin_sum_fourth);
            if (got.bin_hits !== want.bin_hits)
               report_mismatch("bin_hits", got.bin_hits, want.bin_hits);
            if (got.dose_total !== want.dose_total)
               report_mismatch("dose_total", got.dose_total, want.dose_total);
            if (got.event_sum !== want.event_sum)
               report_mismatch("event_sum", got.event_sum, want.event_sum);
         end
      end
   end

   // Random back-pressure: ready held low for a random stall after each result beat.
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp_taken) stall_left = $urandom_range(0, 3);
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      req_item_type it;
      for (int i = 0; i < NBINS; i++) begin
         flux_m[i] = '0; prev_m[i] = '0; mom2_m[i] = '0;
         mom3_m[i] = '0; mom4_m[i] = '0; hits_m[i] = '0;
      end
      for (int d = 0; d < NDOSE; d++) dose_m[d] = '0;
      mask_m = 7'd1;
      used_m = 7'd64;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field, each op, spare op, bad dose select.
      csr_write(REG_DOSE_MASK, 32'h7F);
      it = '0;
      it.op = OP_FILL; it.bin = 6'd0; it.weight = 32'hFFFF_FFFF;
      for (int d = 0; d < NDOSE; d++) it.coef[d] = 32'hFFFF_FFFF;
      it.dose_select = 3'd0;
      pending_reqs.push_back(it);
      it.bin = 6'd63; it.dose_select = 3'd6;
      pending_reqs.push_back(it);
      it.weight = 32'h0001_0000; it.bin = 6'd1;
      for (int d = 0; d < NDOSE; d++) it.coef[d] = 32'h0;
      it.dose_select = 3'd7;
      pending_reqs.push_back(it);
      it.op = OP_EVENT; it.bin = 6'd0;
      pending_reqs.push_back(it);
      it.op = OP_EVENT;
      pending_reqs.push_back(it);
      it.op = OP_READ; it.bin = 6'd63; it.dose_select = 3'd3;
      pending_reqs.push_back(it);
      it.op = OP_SPARE; it.bin = 6'd1; it.dose_select = 3'd7;
      pending_reqs.push_back(it);
      // Repeated large fills drive flux toward saturation.
      it.op = OP_FILL; it.bin = 6'd2; it.weight = 32'hFFFF_FFFF;
      for (int d = 0; d < NDOSE; d++) it.coef[d] = 32'hFFFF_FFFF;
      for (int k = 0; k < 4; k++) pending_reqs.push_back(it);
      it.op = OP_EVENT;
      pending_reqs.push_back(it);
      wait_drained();

      // Zero bins walked.
      csr_write(REG_BINS_USED, 32'd0);
      csr_write(REG_DOSE_MASK, 32'h0);
      for (int k = 0; k < 3; k++) pending_reqs.push_back(rand_req(60));
      it = rand_req(0); it.op = OP_EVENT;
      pending_reqs.push_back(it);
      wait_drained();

      // Random phases across register settings, the extremes among them.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(REG_BINS_USED, 32'd1); csr_write(REG_DOSE_MASK, 32'h55); end
            1: begin csr_write(REG_BINS_USED, 32'd8); csr_write(REG_DOSE_MASK, 32'h2A); end
            2: begin csr_write(REG_BINS_USED, 32'd64); csr_write(REG_DOSE_MASK, 32'h7F); end
            3: begin csr_write(REG_BINS_USED, 32'd127); csr_write(REG_DOSE_MASK, 32'h1); end
            4: begin
               csr_write(REG_BINS_USED, 32'($urandom_range(1, 64)));
               csr_write(REG_DOSE_MASK, 32'($urandom_range(0, 127)));
            end
            default: begin csr_write(REG_BINS_USED, 32'd3); csr_write(REG_DOSE_MASK, 32'h7F); end
         endcase
         for (int k = 0; k < 75; k++) pending_reqs.push_back(rand_req(60));
         wait_drained();
      end
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule : tb_weighted_bin_tally_moments
`default_nettype wire
